@@ hw/rtl/running_lcm_fold_assert.svh @@
// assertion macros used by the running lcm fold controller
`ifndef RUNNING_LCM_FOLD_ASSERT_SVH
`define RUNNING_LCM_FOLD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLF_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define RLF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/rlf_pkg.sv @@
// types shared by the running lcm fold controller and datapath
`timescale 1ns / 1ps

package rlf_pkg;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CLASS  = 9'b000000010,
    ST_NEXT_G = 9'b000000100,
    ST_DIV_G  = 9'b000001000,
    ST_G_UPD  = 9'b000010000,
    ST_DIV_Q  = 9'b000100000,
    ST_MUL_LD = 9'b001000000,
    ST_MUL    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } rlf_state_t;

  typedef struct packed {
    logic load;
    logic gcd_init;
    logic gcd_start;
    logic gcd_update;
    logic quot_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic commit;
  } rlf_cmd_t;

  typedef struct packed {
    logic quick;
    logic gb_zero;
    logic cnt_zero;
  } rlf_status_t;

endpackage

@@ hw/rtl/rlf_dpath.sv @@
// datapath: operand registers, euclid pair, bit-serial divider and multiplier
`timescale 1ns / 1ps

module rlf_dpath
  import rlf_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] in_operand,
  input  logic                   in_first_item,
  input  rlf_cmd_t               cmd,
  output rlf_status_t            st,
  output logic [VALUE_WIDTH-1:0] running_lcm,
  output logic                   overflow
);

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH-1:0] ALL_ONES = {VALUE_WIDTH{1'b1}};

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   sticky_r, sticky_nxt;
  logic [VALUE_WIDTH-1:0] opnd_r;
  logic                   first_r;
  logic [VALUE_WIDTH-1:0] ga_r, gb_r;
  logic [VALUE_WIDTH-1:0] dvd_r, dsr_r, rem_r;
  logic [VALUE_WIDTH-1:0] prod_r;
  logic                   povf_r;
  logic [CW-1:0]          cnt_r;

  logic [VALUE_WIDTH:0]   rem_t;
  logic                   ge;
  logic [VALUE_WIDTH:0]   rem_sub;
  logic [VALUE_WIDTH+1:0] msum;

  // one restoring division step
  assign rem_t   = {rem_r, dvd_r[VALUE_WIDTH-1]};
  assign ge      = rem_t >= {1'b0, dsr_r};
  assign rem_sub = rem_t - {1'b0, dsr_r};

  // one msb-first shift-add multiply step
  assign msum = {1'b0, prod_r, 1'b0}
              + {2'b00, (dvd_r[VALUE_WIDTH-1] ? opnd_r : {VALUE_WIDTH{1'b0}})};

  always_comb begin
    acc_nxt    = acc_r;
    sticky_nxt = sticky_r;
    if (first_r) begin
      acc_nxt    = opnd_r;
      sticky_nxt = 1'b0;
    end else if (opnd_r == '0 || acc_r == '0) begin
      acc_nxt = '0;
    end else if (sticky_r || povf_r) begin
      acc_nxt    = ALL_ONES;
      sticky_nxt = 1'b1;
    end else begin
      acc_nxt = prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      sticky_r <= 1'b0;
    end else if (cmd.commit) begin
      acc_r    <= acc_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r  <= in_operand;
      first_r <= in_first_item;
    end
    if (cmd.gcd_init) begin
      ga_r <= acc_r;
      gb_r <= opnd_r;
    end else if (cmd.gcd_update) begin
      ga_r <= gb_r;
      gb_r <= rem_r;
    end
    if (cmd.gcd_start) begin
      dvd_r <= ga_r;
      dsr_r <= gb_r;
      rem_r <= '0;
      cnt_r <= CNT_LAST;
    end else if (cmd.quot_start) begin
      dvd_r <= acc_r;
      dsr_r <= ga_r;
      rem_r <= '0;
      cnt_r <= CNT_LAST;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[VALUE_WIDTH-2:0], ge};
      rem_r <= ge ? rem_sub[VALUE_WIDTH-1:0] : rem_t[VALUE_WIDTH-1:0];
      cnt_r <= cnt_r - 1'b1;
    end else if (cmd.mul_start) begin
      prod_r <= '0;
      povf_r <= 1'b0;
      cnt_r  <= CNT_LAST;
    end else if (cmd.mul_step) begin
      prod_r <= msum[VALUE_WIDTH-1:0];
      povf_r <= povf_r | (msum[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b00);
      dvd_r  <= {dvd_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign st.quick    = first_r || (opnd_r == '0) || (acc_r == '0) || sticky_r;
  assign st.gb_zero  = (gb_r == '0);
  assign st.cnt_zero = (cnt_r == '0);

  assign running_lcm = acc_r;
  assign overflow    = sticky_r;

endmodule

@@ hw/rtl/rlf_ctrl.sv @@
// controller: sequences euclid divisions, quotient, multiply and result beat
`timescale 1ns / 1ps
`include "running_lcm_fold_assert.svh"

module rlf_ctrl
  import rlf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  rlf_status_t st,
  output rlf_cmd_t    cmd
);

  rlf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (st.quick) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = ST_NEXT_G;
        end
      end
      ST_NEXT_G: begin
        if (st.gb_zero) begin
          cmd.quot_start = 1'b1;
          state_nxt      = ST_DIV_Q;
        end else begin
          cmd.gcd_start = 1'b1;
          state_nxt     = ST_DIV_G;
        end
      end
      ST_DIV_G: begin
        cmd.div_step = 1'b1;
        if (st.cnt_zero) state_nxt = ST_G_UPD;
      end
      ST_G_UPD: begin
        cmd.gcd_update = 1'b1;
        state_nxt      = ST_NEXT_G;
      end
      ST_DIV_Q: begin
        cmd.div_step = 1'b1;
        if (st.cnt_zero) state_nxt = ST_MUL_LD;
      end
      ST_MUL_LD: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.cnt_zero) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RLF_ASSERT_NEXT(a_accept_to_class, in_valid && in_ready, state_r == ST_CLASS, "beat not classified")
  `RLF_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid_r || out_ready, "result overwritten")
  `RLF_ASSERT_NOW(a_valid_from_commit, $rose(out_valid_r), $past(cmd.commit), "result without commit")

endmodule

@@ hw/rtl/running_lcm_fold.sv @@
// first, zero or saturated items go from classification straight to the result
// otherwise euclid divisions run until the remainder is zero, then the quotient
// and multiply follow; the shared divider yields one bit per cycle
// one item in flight; the next beat is taken while a result waits in the output
// synchronous active-low reset clears accumulator, overflow flag and control
`timescale 1ns / 1ps

module running_lcm_fold
  import rlf_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_operand,
  input  logic                   in_first_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_running_lcm,
  output logic                   out_overflow
);

  rlf_cmd_t    cmd;
  rlf_status_t st;

  rlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  rlf_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_operand    (in_operand),
    .in_first_item (in_first_item),
    .cmd           (cmd),
    .st            (st),
    .running_lcm   (out_running_lcm),
    .overflow      (out_overflow)
  );

endmodule
